### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WQC_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define WQC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define WQC_ASSERT_IMPLIES(label, ante, cons)
`define WQC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/wqc_pkg.sv
// ----------------------------------------------------------------------------
// wqc_pkg
// Shared types and constants of the weighted quorum checker.
// ----------------------------------------------------------------------------
package wqc_pkg;

   // field widths
   localparam int CMD_W    = 3;
   localparam int NODE_W   = 4;
   localparam int RACK_W   = 16;
   localparam int RTT_W    = 20;
   localparam int LOSS_W   = 17;
   localparam int WEIGHT_W = 17;
   localparam int ACK_W    = 8;
   localparam int WSUM_W   = 24;
   localparam int MODE_W   = 2;
   localparam int CSIZE_W  = 5;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_QUORUM_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_SIZE = 1'b1;

   localparam logic [MODE_W-1:0]  MODE_RESET  = 2'd0;
   localparam logic [CSIZE_W-1:0] CSIZE_RESET = 5'd5;

   // quorum rules
   localparam logic [MODE_W-1:0] MODE_MAJORITY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FLEXIBLE = 2'd1;
   localparam int FLEX_MIN_ACKS = 2;
   localparam int DYN_SUM_MULT  = 20;
   localparam int DYN_HC_MULT   = 458752;   // 7 * 2^16
   localparam int DYN_SUM_W     = 29;       // width of 20 * weight sum
   localparam int DYN_HC_MULT_W = 19;

   // saturation and weight constants
   localparam logic [ACK_W-1:0]    ACK_MAX    = 8'hFF;
   localparam logic [WSUM_W-1:0]   WSUM_MAX   = 24'hFF_FFFF;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;
   localparam logic [RACK_W-1:0]   RACK_UNKNOWN = 16'd1;

   // weight denominator: 163840 + 512*max(0, rtt-32) + 5*min(loss, 65536)
   localparam int DEN_W = 30;
   localparam logic [DEN_W-1:0]  DEN_BASE  = 30'd163840;
   localparam logic [RTT_W-1:0]  RTT_FLOOR = 20'd32;
   localparam logic [LOSS_W-1:0] LOSS_MAX  = 17'h1_0000;
   localparam int RTT_SHIFT = 9;

   // divider: weight = floor(10737418240 / den)
   localparam int DIV_NUM_W = 34;
   localparam logic [DIV_NUM_W-1:0] DIV_NUM = 34'h2_8000_0000;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd34;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER  = 3'd0,
      CMD_TELEMETRY = 3'd1,
      CMD_ACK       = 3'd2,
      CMD_EVALUATE  = 3'd3,
      CMD_READ      = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_PUSH
   } state_type;

endpackage

### rtl/core/wqc_divider.sv
// ----------------------------------------------------------------------------
// wqc_divider
// Restoring divider for the node weight: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wqc_divider
   import wqc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DEN_W-1:0]    divisor,
   output logic                done,
   output logic [WEIGHT_W-1:0] quotient
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [WEIGHT_W-1:0]  q_ff, q_in;
   logic [DEN_W:0]       trial;
   logic                 fits;

   // shift in the next dividend bit and try the subtraction
   assign trial = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   // step the long division
   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = DIV_STEPS;
         rem_in = '0;
         den_in = divisor;
         num_in = DIV_NUM;
         q_in   = '0;
      end else if (cnt_ff != '0) begin
         if (fits) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = DEN_W'(trial);
         end
         num_in  = {num_ff[DIV_NUM_W-2:0], 1'b0};
         q_in    = {q_ff[WEIGHT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

### rtl/core/weighted_quorum_checker_unit.sv
// ----------------------------------------------------------------------------
// weighted_quorum_checker_unit
// Node table with per-node Q16 weights and a commit quorum accumulator.
// ----------------------------------------------------------------------------
// One item is handled at a time. The table is read at the accepting edge.
// Register, ack, evaluate and read items then update the state and stage
// the result in the lookup state and load the output register in the push
// state. The next item is accepted only once the block is back in idle, so
// a new item is not taken before the last one is through. A telemetry
// update for a known node also runs the bit-serial weight divider. That is
// 34 steps and a registered done that hands over the quotient. The rack and
// weight of each node live in a synchronous table read once per item. The
// valid and healthy bits and the healthy-node count are kept in flops, so
// the block needs no clearing pass after reset. The result register lets
// the next item in while a result still waits to be taken. That item then
// holds in the push state until the waiting result is taken.
`include "assert_macros.svh"

module weighted_quorum_checker_unit
   import wqc_pkg::*;
#(
   parameter int MAX_NODES = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   // request items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [NODE_W-1:0]     req_node_id,
   input  logic [RACK_W-1:0]     req_rack_number,
   input  logic [RTT_W-1:0]      req_round_trip,
   input  logic [LOSS_W-1:0]     req_loss_fraction,
   input  logic                  req_healthy_flag,
   // response items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_quorum_met,
   output logic [ACK_W-1:0]      rsp_ack_total,
   output logic [WSUM_W-1:0]     rsp_weight_total,
   output logic [RACK_W-1:0]     rsp_node_rack,
   output logic [WEIGHT_W-1:0]   rsp_node_weight,
   output logic                  rsp_node_known
);

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int HC_W  = $clog2(MAX_NODES + 1);
   localparam int CMP_W = (HC_W + DYN_HC_MULT_W > DYN_SUM_W) ?
                          (HC_W + DYN_HC_MULT_W) : DYN_SUM_W;

   // control state
   state_type            state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [CSIZE_W-1:0]   csize_ff;
   logic [MAX_NODES-1:0] valid_ff, valid_in;
   logic [MAX_NODES-1:0] healthy_ff, healthy_in;
   logic [HC_W-1:0]      hcount_ff, hcount_in;
   logic [ACK_W-1:0]     ack_ff, ack_in;
   logic [WSUM_W-1:0]    wsum_ff, wsum_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // latched item
   command_type          cmd_ff;
   logic [NODE_W-1:0]    node_ff;
   logic [RACK_W-1:0]    rack_ff;
   logic [RTT_W-1:0]     rtt_ff;
   logic [LOSS_W-1:0]    loss_ff;
   logic                 health_ff;

   // node table
   logic [RACK_W-1:0]    rack_mem   [MAX_NODES];
   logic [WEIGHT_W-1:0]  weight_mem [MAX_NODES];
   logic [RACK_W-1:0]    rack_rd_ff;
   logic [WEIGHT_W-1:0]  weight_rd_ff;
   logic [IDX_W-1:0]     req_addr;
   logic [IDX_W-1:0]     addr;
   logic                 rack_we;
   logic                 weight_we;
   logic [WEIGHT_W-1:0]  weight_wr;

   // staged result
   logic                 res_met_ff;
   logic [ACK_W-1:0]     res_acks_ff;
   logic [WSUM_W-1:0]    res_wsum_ff;
   logic [RACK_W-1:0]    res_rack_ff;
   logic [WEIGHT_W-1:0]  res_weight_ff;
   logic                 res_known_ff;

   // output register
   logic                 out_met_ff;
   logic [ACK_W-1:0]     out_acks_ff;
   logic [WSUM_W-1:0]    out_wsum_ff;
   logic [RACK_W-1:0]    out_rack_ff;
   logic [WEIGHT_W-1:0]  out_weight_ff;
   logic                 out_known_ff;

   // sequencer controls
   logic accept;
   logic lookup_act;
   logic div_start;
   logic div_fin;
   logic load_res;
   logic push_go;

   // lookup and datapath
   logic                 in_range;
   logic                 known_cur;
   logic                 healthy_cur;
   logic                 known_new;
   logic                 healthy_new;
   logic [RACK_W-1:0]    rack_new;
   logic [WEIGHT_W-1:0]  weight_new;
   logic [WEIGHT_W-1:0]  weight_out;
   logic [ACK_W-1:0]     ack_upd;
   logic [WSUM_W-1:0]    wsum_upd;
   logic [WSUM_W:0]      wsum_add;
   logic                 decision;
   logic [CSIZE_W-1:0]   flex_thr;
   logic [CMP_W-1:0]     dyn_lhs;
   logic [CMP_W-1:0]     dyn_rhs;
   logic [RTT_W-1:0]     rtt_over;
   logic [LOSS_W-1:0]    loss_clip;
   logic [DEN_W-1:0]     den;
   logic                 div_done;
   logic [WEIGHT_W-1:0]  div_q;

   assign accept   = req_valid && req_ready;
   assign req_addr = IDX_W'(req_node_id);
   assign addr     = IDX_W'(node_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         csize_ff <= CSIZE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_QUORUM_MODE:  mode_ff  <= MODE_W'(csr_write_data);
            CSR_CLUSTER_SIZE: csize_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (cmd_ff == CMD_TELEMETRY && known_cur) state_in = ST_DIVIDE;
            else state_in = ST_PUSH;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      lookup_act = 1'b0;
      div_start  = 1'b0;
      div_fin    = 1'b0;
      load_res   = 1'b0;
      push_go    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_LOOKUP: begin
            lookup_act = 1'b1;
            div_start  = (cmd_ff == CMD_TELEMETRY) && known_cur;
            load_res   = !div_start;
         end
         ST_DIVIDE: begin
            div_fin  = div_done;
            load_res = div_done;
         end
         ST_PUSH: begin
            push_go = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // capture the item
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= command_type'(req_command);
         node_ff   <= req_node_id;
         rack_ff   <= req_rack_number;
         rtt_ff    <= req_round_trip;
         loss_ff   <= req_loss_fraction;
         health_ff <= req_healthy_flag;
      end
   end

   // table: read on accept, write back in the lookup or divide state; the next
   // read comes only after the push state, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rack_rd_ff   <= rack_mem[req_addr];
         weight_rd_ff <= weight_mem[req_addr];
      end
      if (rack_we)   rack_mem[addr]   <= rack_ff;
      if (weight_we) weight_mem[addr] <= weight_wr;
   end

   assign rack_we   = lookup_act && (cmd_ff == CMD_REGISTER) && in_range;
   assign weight_we = rack_we || div_fin;
   assign weight_wr = div_fin ? div_q : WEIGHT_ONE;

   // node lookup
   assign in_range    = (32'(node_ff) < 32'(MAX_NODES));
   assign known_cur   = in_range && valid_ff[addr];
   assign healthy_cur = known_cur && healthy_ff[addr];

   // weight denominator and divider
   assign rtt_over  = (rtt_ff > RTT_FLOOR) ? (rtt_ff - RTT_FLOOR) : '0;
   assign loss_clip = (loss_ff > LOSS_MAX) ? LOSS_MAX : loss_ff;
   assign den = DEN_BASE + (DEN_W'(rtt_over) << RTT_SHIFT)
              + (DEN_W'(loss_clip) << 2) + DEN_W'(loss_clip);

   wqc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (den),
      .done     (div_done),
      .quotient (div_q)
   );

   // table flags and healthy-node count
   always_comb begin
      valid_in   = valid_ff;
      healthy_in = healthy_ff;
      hcount_in  = hcount_ff;
      if (rack_we) begin
         valid_in[addr]   = 1'b1;
         healthy_in[addr] = 1'b1;
         if (!healthy_cur) hcount_in = hcount_ff + 1'b1;
      end else if (div_fin) begin
         healthy_in[addr] = health_ff;
         if (!healthy_cur && health_ff)      hcount_in = hcount_ff + 1'b1;
         else if (healthy_cur && !health_ff) hcount_in = hcount_ff - 1'b1;
      end
   end

   // round accumulators
   assign wsum_add = {1'b0, wsum_ff} + (WSUM_W + 1)'(weight_rd_ff);

   always_comb begin
      ack_upd  = ack_ff;
      wsum_upd = wsum_ff;
      if (cmd_ff == CMD_ACK) begin
         if (ack_ff != ACK_MAX) ack_upd = ack_ff + 1'b1;
         if (healthy_cur) begin
            wsum_upd = wsum_add[WSUM_W] ? WSUM_MAX : wsum_add[WSUM_W-1:0];
         end
      end
   end

   always_comb begin
      ack_in  = ack_ff;
      wsum_in = wsum_ff;
      if (lookup_act) begin
         if (cmd_ff == CMD_EVALUATE) begin
            ack_in  = '0;
            wsum_in = '0;
         end else begin
            ack_in  = ack_upd;
            wsum_in = wsum_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         healthy_ff <= '0;
         hcount_ff  <= '0;
         ack_ff     <= '0;
         wsum_ff    <= '0;
      end else begin
         valid_ff   <= valid_in;
         healthy_ff <= healthy_in;
         hcount_ff  <= hcount_in;
         ack_ff     <= ack_in;
         wsum_ff    <= wsum_in;
      end
   end

   // quorum rule
   assign flex_thr = ((csize_ff >> 1) < CSIZE_W'(FLEX_MIN_ACKS)) ?
                     CSIZE_W'(FLEX_MIN_ACKS) : (csize_ff >> 1);
   assign dyn_lhs  = CMP_W'(wsum_ff) * CMP_W'(DYN_SUM_MULT);
   assign dyn_rhs  = CMP_W'(hcount_ff) * CMP_W'(DYN_HC_MULT);

   always_comb begin
      case (mode_ff)
         MODE_MAJORITY: decision = (ack_ff >= ACK_W'((csize_ff >> 1) + 1'b1));
         MODE_FLEXIBLE: decision = (ack_ff >= ACK_W'(flex_thr));
         default:       decision = (dyn_lhs >= dyn_rhs) && (ack_ff != '0);
      endcase
   end

   // node fields after the item
   always_comb begin
      known_new   = known_cur;
      healthy_new = healthy_cur;
      rack_new    = rack_rd_ff;
      weight_new  = weight_rd_ff;
      case (cmd_ff)
         CMD_REGISTER: begin
            known_new   = in_range;
            healthy_new = 1'b1;
            rack_new    = rack_ff;
            weight_new  = WEIGHT_ONE;
         end
         CMD_TELEMETRY: begin
            healthy_new = known_cur && health_ff;
            weight_new  = div_q;
         end
         default: ;
      endcase
   end

   assign weight_out = !(known_new && healthy_new) ? '0 :
                       (mode_ff[1] ? weight_new : WEIGHT_ONE);

   // stage the result
   always_ff @(posedge clock) begin
      if (load_res) begin
         res_met_ff    <= (cmd_ff == CMD_EVALUATE) && decision;
         res_acks_ff   <= ack_upd;
         res_wsum_ff   <= wsum_upd;
         res_rack_ff   <= known_new ? rack_new : RACK_UNKNOWN;
         res_weight_ff <= weight_out;
         res_known_ff  <= known_new;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push_go)        rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         out_met_ff    <= res_met_ff;
         out_acks_ff   <= res_acks_ff;
         out_wsum_ff   <= res_wsum_ff;
         out_rack_ff   <= res_rack_ff;
         out_weight_ff <= res_weight_ff;
         out_known_ff  <= res_known_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_quorum_met   = out_met_ff;
   assign rsp_ack_total    = out_acks_ff;
   assign rsp_weight_total = out_wsum_ff;
   assign rsp_node_rack    = out_rack_ff;
   assign rsp_node_weight  = out_weight_ff;
   assign rsp_node_known   = out_known_ff;

   // checks
   `WQC_ASSERT_IMPLIES(a_hcount_range, 1'b1, 32'(hcount_ff) <= 32'(MAX_NODES))
   `WQC_ASSERT_NEXT(a_eval_clears, lookup_act && (cmd_ff == CMD_EVALUATE), (ack_ff == '0) && (wsum_ff == '0))
   `WQC_ASSERT_IMPLIES(a_div_in_state, div_done, state_ff == ST_DIVIDE)
   `WQC_ASSERT_IMPLIES(a_rsp_from_push, $rose(rsp_valid_ff), $past(state_ff) == ST_PUSH)

endmodule
